// ----- hw/rtl/matrix_multiply_engine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion macros for the matrix multiply engine checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared constants, codes and types of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int PROD_W         = 35;
  localparam int CMP_W          = 6;
  localparam int IDX_W          = 4;
  localparam int CFG_W          = 4;
  localparam int CFG_IDX_W      = 2;

  localparam logic [1:0] OP_WR_A = 2'd0;
  localparam logic [1:0] OP_WR_B = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic valid;
    logic mul;
    logic status;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic             en_a;
    logic             en_b;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] idx;
  } wr_t;

endpackage

// ----- hw/rtl/matrix_multiply_engine_unit.sv -----
// A result passes through the generator register and then the chain of
// MAX_DIM multiply-add cells. A write transaction yields one result; a
// multiply yields rows_a * cols_b results (each size read as one if zero and
// clamped to MAX_DIM), one per cycle while out_ready does not stall the chain.
// A new transaction is accepted once the generator is idle and every cell
// but the last has drained.
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Stores matrices A and B across a chain of cells and streams the product.
// Reset is synchronous and clears both matrices and sets all sizes to one.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_op,
  input  logic [2:0]                           in_row,
  input  logic [2:0]                           in_col,
  input  logic signed [15:0]                   in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_status,
  output logic [2:0]                           out_out_row,
  output logic [2:0]                           out_out_col,
  output logic signed [mme_pkg::PROD_W-1:0]    out_product,
  output logic                                 out_last
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int CW = mme_pkg::CMP_W;

  logic [mme_pkg::CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [CW-1:0]             nr, ni, nc;
  logic [CW-1:0]             lim_r, lim_c;
  logic                      acc, in_range, chain_busy, adv;
  mme_pkg::wr_t              wr;
  logic signed [ELEM_WIDTH-1:0] wr_data;

  mme_pkg::ctl_t gen_ctl_r, gen_ctl_nxt;
  logic [IW-1:0] gen_i_r, gen_i_nxt, gen_j_r, gen_j_nxt;

  mme_pkg::ctl_t                      ctl_w  [MAX_DIM+1];
  logic [IW-1:0]                      row_w  [MAX_DIM+1];
  logic [IW-1:0]                      col_w  [MAX_DIM+1];
  logic signed [mme_pkg::PROD_W-1:0]  psum_w [MAX_DIM+1];
  logic [MAX_DIM-2:0]                 busy_vec;

  function automatic logic [CW-1:0] eff_dim(input logic [mme_pkg::CFG_W-1:0] r);
    logic [CW-1:0] e;
    e = CW'(r);
    if (e == '0) begin
      return CW'(1);
    end else if (e > CW'(MAX_DIM)) begin
      return CW'(MAX_DIM);
    end
    return e;
  endfunction

  assign nr = eff_dim(rows_a_r);
  assign ni = eff_dim(inner_dim_r);
  assign nc = eff_dim(cols_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mme_pkg::CFG_W'(1);
      inner_dim_r <= mme_pkg::CFG_W'(1);
      cols_b_r    <= mme_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::REG_ROWS_A:    rows_a_r    <= cfg_data;
        mme_pkg::REG_INNER_DIM: inner_dim_r <= cfg_data;
        mme_pkg::REG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_DIM - 1; g++) begin : g_busy
      assign busy_vec[g] = ctl_w[g+1].valid;
    end
  endgenerate

  assign chain_busy = |busy_vec;
  assign in_ready   = !gen_ctl_r.valid && !chain_busy;
  assign acc        = in_valid && in_ready;
  assign adv        = !ctl_w[MAX_DIM].valid || out_ready;

  assign lim_r    = (in_op == mme_pkg::OP_WR_A) ? nr : ni;
  assign lim_c    = (in_op == mme_pkg::OP_WR_A) ? ni : nc;
  assign in_range = (CW'(in_row) < lim_r) && (CW'(in_col) < lim_c);
  assign wr_data  = ELEM_WIDTH'(in_value);

  always_comb begin
    wr.en_a = acc && in_range && (in_op == mme_pkg::OP_WR_A);
    wr.en_b = acc && in_range && (in_op == mme_pkg::OP_WR_B);
    if (in_op == mme_pkg::OP_WR_A) begin
      wr.sel = mme_pkg::IDX_W'(in_col);
      wr.idx = mme_pkg::IDX_W'(in_row);
    end else begin
      wr.sel = mme_pkg::IDX_W'(in_row);
      wr.idx = mme_pkg::IDX_W'(in_col);
    end
  end

  always_comb begin
    gen_ctl_nxt = gen_ctl_r;
    gen_i_nxt   = gen_i_r;
    gen_j_nxt   = gen_j_r;
    if (acc) begin
      gen_ctl_nxt.valid = 1'b1;
      gen_i_nxt         = '0;
      gen_j_nxt         = '0;
      case (in_op)
        mme_pkg::OP_WR_A, mme_pkg::OP_WR_B: begin
          gen_ctl_nxt.mul    = 1'b0;
          gen_ctl_nxt.status = !in_range;
          gen_ctl_nxt.last   = 1'b1;
        end
        mme_pkg::OP_MUL: begin
          gen_ctl_nxt.mul    = 1'b1;
          gen_ctl_nxt.status = 1'b0;
          gen_ctl_nxt.last   = (nr == CW'(1)) && (nc == CW'(1));
        end
        default: begin
          gen_ctl_nxt.mul    = 1'b0;
          gen_ctl_nxt.status = 1'b1;
          gen_ctl_nxt.last   = 1'b1;
        end
      endcase
    end else if (adv && gen_ctl_r.valid) begin
      if (gen_ctl_r.last) begin
        gen_ctl_nxt.valid = 1'b0;
      end else begin
        if (CW'(gen_j_r) + CW'(1) == nc) begin
          gen_j_nxt = '0;
          gen_i_nxt = gen_i_r + IW'(1);
        end else begin
          gen_j_nxt = gen_j_r + IW'(1);
        end
        gen_ctl_nxt.last = (CW'(gen_i_nxt) + CW'(1) == nr) &&
                           (CW'(gen_j_nxt) + CW'(1) == nc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_ctl_r <= '0;
    end else begin
      gen_ctl_r <= gen_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_i_r <= gen_i_nxt;
    gen_j_r <= gen_j_nxt;
  end

  assign ctl_w[0]  = gen_ctl_r;
  assign row_w[0]  = gen_i_r;
  assign col_w[0]  = gen_j_r;
  assign psum_w[0] = '0;

  generate
    for (g = 0; g < MAX_DIM; g++) begin : g_cell
      mme_cell #(
        .K          (g),
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .IW         (IW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ni      (ni),
        .wr      (wr),
        .wr_data (wr_data),
        .ctl_i   (ctl_w[g]),
        .row_i   (row_w[g]),
        .col_i   (col_w[g]),
        .psum_i  (psum_w[g]),
        .ctl_o   (ctl_w[g+1]),
        .row_o   (row_w[g+1]),
        .col_o   (col_w[g+1]),
        .psum_o  (psum_w[g+1])
      );
    end
  endgenerate

  assign out_valid   = ctl_w[MAX_DIM].valid;
  assign out_status  = ctl_w[MAX_DIM].status;
  assign out_last    = ctl_w[MAX_DIM].last;
  assign out_out_row = 3'(row_w[MAX_DIM]);
  assign out_out_col = 3'(col_w[MAX_DIM]);
  assign out_product = psum_w[MAX_DIM];

endmodule

// ----- hw/rtl/mme_cell.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one column of A and one row of B and adds one product term to the
// partial sum that passes through it.
// ----------------------------------------------------------------------------
module mme_cell #(
  parameter int K          = 0,
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF,
  parameter int IW         = $clog2(MAX_DIM)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic [mme_pkg::CMP_W-1:0]          ni,
  input  mme_pkg::wr_t                       wr,
  input  logic signed [ELEM_WIDTH-1:0]       wr_data,
  input  mme_pkg::ctl_t                      ctl_i,
  input  logic [IW-1:0]                      row_i,
  input  logic [IW-1:0]                      col_i,
  input  logic signed [mme_pkg::PROD_W-1:0]  psum_i,
  output mme_pkg::ctl_t                      ctl_o,
  output logic [IW-1:0]                      row_o,
  output logic [IW-1:0]                      col_o,
  output logic signed [mme_pkg::PROD_W-1:0]  psum_o
);

  logic signed [ELEM_WIDTH-1:0]       a_col_r [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0]       b_row_r [MAX_DIM];
  mme_pkg::ctl_t                      ctl_r;
  logic [IW-1:0]                      row_r;
  logic [IW-1:0]                      col_r;
  logic signed [mme_pkg::PROD_W-1:0]  psum_r;
  logic signed [2*ELEM_WIDTH-1:0]     mul;
  logic                               active;
  logic signed [mme_pkg::PROD_W-1:0]  psum_nxt;

  assign mul      = a_col_r[row_i] * b_row_r[col_i];
  assign active   = ctl_i.valid && ctl_i.mul && (mme_pkg::CMP_W'(K) < ni);
  assign psum_nxt = active ? (psum_i + mme_pkg::PROD_W'(mul)) : psum_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < MAX_DIM; n++) begin
        a_col_r[n] <= '0;
        b_row_r[n] <= '0;
      end
    end else begin
      if (wr.en_a && wr.sel == mme_pkg::IDX_W'(K)) begin
        a_col_r[wr.idx[IW-1:0]] <= wr_data;
      end
      if (wr.en_b && wr.sel == mme_pkg::IDX_W'(K)) begin
        b_row_r[wr.idx[IW-1:0]] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r  <= row_i;
      col_r  <= col_i;
      psum_r <= psum_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign row_o  = row_r;
  assign col_o  = col_r;
  assign psum_o = psum_r;

endmodule

// ----- hw/rtl/mme_checker.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_unit_assert.svh"

module mme_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_we,
  input logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [mme_pkg::CFG_W-1:0]          cfg_data,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [1:0]                         in_op,
  input logic [2:0]                         in_row,
  input logic [2:0]                         in_col,
  input logic signed [15:0]                 in_value,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_status,
  input logic [2:0]                         out_out_row,
  input logic [2:0]                         out_out_col,
  input logic signed [mme_pkg::PROD_W-1:0]  out_product,
  input logic                               out_last
);

  `MME_ASSERT_NXT(a_ready_drops, in_valid && in_ready, !in_ready, "ready held after transaction")
  `MME_ASSERT_IMP(a_status_last, out_valid && out_status, out_last, "error result not last")
  `MME_ASSERT_IMP(a_status_zero, out_valid && out_status, out_product == '0, "error result has data")
  `MME_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_product), "result dropped")

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);
